// ===== rtl/core/sce_pkg.sv =====
// Shared types, request codes and status codes for the stack calculator engine.
package sce_pkg;

	localparam int VAL_W           = 64;
	localparam int REQ_W           = 4;
	localparam int STATUS_W        = 2;
	localparam int DEPTH_OUT_W     = 7;
	localparam int STACK_DEPTH_DEF = 64;

	localparam logic [REQ_W-1:0] REQ_PUSH   = 4'd0;
	localparam logic [REQ_W-1:0] REQ_DOT    = 4'd1;
	localparam logic [REQ_W-1:0] REQ_ADD    = 4'd2;
	localparam logic [REQ_W-1:0] REQ_SWAP   = 4'd3;
	localparam logic [REQ_W-1:0] REQ_SUB    = 4'd4;
	localparam logic [REQ_W-1:0] REQ_MUL    = 4'd5;
	localparam logic [REQ_W-1:0] REQ_DIV    = 4'd6;
	localparam logic [REQ_W-1:0] REQ_MOD    = 4'd7;
	localparam logic [REQ_W-1:0] REQ_ADD_OF = 4'd8;
	localparam logic [REQ_W-1:0] REQ_SUB_OF = 4'd9;
	localparam logic [REQ_W-1:0] REQ_MUL_OF = 4'd10;
	localparam logic [REQ_W-1:0] REQ_UOF    = 4'd11;
	localparam logic [REQ_W-1:0] REQ_SOF    = 4'd12;
	localparam logic [REQ_W-1:0] REQ_FLAGS  = 4'd13;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd2;

	// Control into the shared multiply/divide unit.
	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	// Status back from the multiply/divide unit.
	typedef struct packed {
		logic busy;
		logic done;
	} md_rsp_t;

endpackage

// ===== rtl/core/sce_if.sv =====
// Handshake interfaces for the request and result channels.
interface sce_req_if import sce_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [VAL_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface sce_rsp_if import sce_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VAL_W-1:0]       out_value;
	logic                   out_valid;
	logic [STATUS_W-1:0]    status;
	logic [DEPTH_OUT_W-1:0] stack_depth;
	logic                   unsigned_overflow;

	modport source (output valid, output out_value, output out_valid, output status,
		output stack_depth, output unsigned_overflow, input ready);
	modport sink   (input valid, input out_value, input out_valid, input status,
		input stack_depth, input unsigned_overflow, output ready);
endinterface

// ===== rtl/core/stack_calculator_engine.sv =====
// Top level of the stack calculator engine: sequencer, stack memory and result register.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | req_type, push_value
//   rsp     | out | valid / ready | out_value, out_valid, status, stack_depth, unsigned_overflow
//
// Push, flag pushes, flags, no-op items, an empty dot and a short swap finish in S_IDLE; a dot
// reads in S_RD1; add and sub read their operands, then S_EXEC; a full swap ends in S_SWAP;
// mul, div and mod wait in S_MD on the 64-step shared unit, which a divide by zero skips.
// Reset clears the entry count, the overflow flag and the sequencer; the stack memory is
// not cleared, since only entries below the count, all written since reset, are ever read.
// One result waits in the output register while the next item runs; another holds the sequencer.
module stack_calculator_engine import sce_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sce_req_if.sink      req,
	sce_rsp_if.source    rsp
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_SWAP = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_MD   = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [REQ_W-1:0] req_q;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             uof_q, uof_d;
	logic [VAL_W-1:0] top_q;
	logic [VAL_W-1:0] next_q;

	logic [VAL_W-1:0] mem [STACK_DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [AW-1:0]    rd_addr;

	logic [CW-1:0] cm1;
	logic [CW-1:0] cm2;
	logic [CW-1:0] base;
	logic          acc;

	logic                fin;
	logic [VAL_W-1:0]    fin_value;
	logic                fin_ov;
	logic [STATUS_W-1:0] fin_status;
	logic                bin_wb;
	logic [VAL_W-1:0]    bin_r;
	logic [STATUS_W-1:0] bin_status;

	logic [VAL_W:0]   add_sum;
	logic [VAL_W-1:0] sub_diff;

	logic [VAL_W-1:0]    res_value_q;
	logic                res_ov_q;
	logic [STATUS_W-1:0] res_status_q;

	logic                   out_full_q;
	logic                   out_load;
	logic [VAL_W-1:0]       out_value_q;
	logic                   out_ov_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [DEPTH_OUT_W-1:0] out_depth_q;
	logic                   out_uof_q;
	logic [CW+DEPTH_OUT_W-1:0] cnt_ext;

	md_req_t          md_req;
	md_rsp_t          md_rsp;
	logic [VAL_W-1:0] md_hi;
	logic [VAL_W-1:0] md_lo;

	assign acc       = req.valid & req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cm1       = cnt_q - CW'(1);
	assign cm2       = cnt_q - CW'(2);
	assign base      = (cnt_q >= CW'(2)) ? cm2 : '0;
	assign rd_addr   = (state_q == S_RD1) ? cm2[AW-1:0] : cm1[AW-1:0];
	assign add_sum   = {1'b0, next_q} + {1'b0, top_q};
	assign sub_diff  = next_q - top_q;
	assign cnt_ext   = {{DEPTH_OUT_W{1'b0}}, cnt_q};
	assign out_load  = (state_q == S_DONE) && (!out_full_q || rsp.ready);

	sce_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.op_a   (next_q),
		.op_b   (top_q),
		.rsp    (md_rsp),
		.res_hi (md_hi),
		.res_lo (md_lo)
	);

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		uof_d         = uof_q;
		wr_en         = 1'b0;
		wr_addr       = cnt_q[AW-1:0];
		wr_data       = req.push_value;
		fin           = 1'b0;
		fin_value     = '0;
		fin_ov        = 1'b0;
		fin_status    = ST_OK;
		bin_wb        = 1'b0;
		bin_r         = '0;
		bin_status    = ST_OK;
		md_req.start  = 1'b0;
		md_req.is_div = (req_q == REQ_DIV) || (req_q == REQ_MOD);

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.req_type) inside
						REQ_PUSH, REQ_UOF, REQ_SOF: begin
							fin = 1'b1;
							if (cnt_q >= CW'(STACK_DEPTH)) begin
								fin_status = ST_FULL;
							end else begin
								wr_en = 1'b1;
								if (req.req_type == REQ_UOF) begin
									wr_data = {{(VAL_W-1){1'b0}}, uof_q};
								end else if (req.req_type == REQ_SOF) begin
									wr_data = '0;
								end
								cnt_d = cnt_q + CW'(1);
							end
						end
						REQ_DOT: begin
							if (cnt_q == '0) begin
								fin    = 1'b1;
								fin_ov = 1'b1;
							end else begin
								state_d = S_RD1;
							end
						end
						REQ_SWAP: begin
							if (cnt_q >= CW'(2)) begin
								state_d = S_RD1;
							end else begin
								fin = 1'b1;
							end
						end
						REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_MOD,
						REQ_ADD_OF, REQ_SUB_OF, REQ_MUL_OF: begin
							state_d = (cnt_q == '0) ? S_EXEC : S_RD1;
						end
						REQ_FLAGS: begin
							fin       = 1'b1;
							fin_ov    = 1'b1;
							// The signed overflow flag is never set.
							fin_value = {{(VAL_W-2){1'b0}}, 1'b0, uof_q};
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_RD1: begin
				if (req_q == REQ_DOT) begin
					fin       = 1'b1;
					fin_ov    = 1'b1;
					fin_value = rdata_q;
					cnt_d     = cm1;
				end else if (cnt_q >= CW'(2)) begin
					state_d = S_RD2;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_RD2: begin
				if (req_q == REQ_SWAP) begin
					wr_en   = 1'b1;
					wr_addr = cm1[AW-1:0];
					wr_data = rdata_q;
					state_d = S_SWAP;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = cm2[AW-1:0];
				wr_data = top_q;
				fin     = 1'b1;
			end
			S_EXEC: begin
				case (req_q) inside
					REQ_ADD, REQ_ADD_OF: begin
						bin_wb = 1'b1;
						bin_r  = add_sum[VAL_W-1:0];
						if (req_q == REQ_ADD_OF) begin
							uof_d = add_sum[VAL_W];
						end
					end
					REQ_SUB, REQ_SUB_OF: begin
						bin_wb = 1'b1;
						bin_r  = sub_diff;
						if (req_q == REQ_SUB_OF) begin
							uof_d = next_q < top_q;
						end
					end
					REQ_DIV, REQ_MOD: begin
						if (top_q == '0) begin
							bin_wb     = 1'b1;
							bin_status = ST_DIV0;
						end else begin
							md_req.start = 1'b1;
							state_d      = S_MD;
						end
					end
					REQ_MUL, REQ_MUL_OF: begin
						md_req.start = 1'b1;
						state_d      = S_MD;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_MD: begin
				if (md_rsp.done) begin
					bin_wb = 1'b1;
					bin_r  = (req_q == REQ_MOD) ? md_hi : md_lo;
					if (req_q == REQ_MUL_OF) begin
						uof_d = md_hi != '0;
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Both operands are popped, so the result always has room.
		if (bin_wb) begin
			wr_en      = 1'b1;
			wr_addr    = base[AW-1:0];
			wr_data    = bin_r;
			cnt_d      = base + CW'(1);
			fin        = 1'b1;
			fin_status = bin_status;
		end
		if (fin) begin
			state_d = S_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			uof_q      <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			uof_q   <= uof_d;
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (rsp.ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q  <= req.req_type;
			top_q  <= '0;
			next_q <= '0;
		end else if (state_q == S_RD1) begin
			top_q <= rdata_q;
		end else if (state_q == S_RD2) begin
			next_q <= rdata_q;
		end
		if (fin) begin
			res_value_q  <= fin_value;
			res_ov_q     <= fin_ov;
			res_status_q <= fin_status;
		end
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_ov_q     <= res_ov_q;
			out_status_q <= res_status_q;
			out_depth_q  <= cnt_ext[DEPTH_OUT_W-1:0];
			out_uof_q    <= uof_q;
		end
	end

	assign rsp.valid             = out_full_q;
	assign rsp.out_value         = out_value_q;
	assign rsp.out_valid         = out_ov_q;
	assign rsp.status            = out_status_q;
	assign rsp.stack_depth       = out_depth_q;
	assign rsp.unsigned_overflow = out_uof_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (int'(wr_addr) < STACK_DEPTH))
		else $error("stack write outside memory");

	a_md_start: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> !md_rsp.busy && (top_q != '0 || !md_req.is_div))
		else $error("multiply/divide started while busy or with zero divisor");

	a_md_done: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == S_MD)
		else $error("multiply/divide result outside wait state");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_full_q && !rsp.ready) |=> state_q == S_DONE)
		else $error("result left sequencer while output register full");

endmodule

// ===== rtl/core/sce_muldiv.sv =====
// Shared iterative unit: shift-add multiply and restoring divide, one bit per cycle.
module sce_muldiv import sce_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  md_req_t          req,
	input  logic [VAL_W-1:0] op_a,
	input  logic [VAL_W-1:0] op_b,
	output md_rsp_t          rsp,
	output logic [VAL_W-1:0] res_hi,
	output logic [VAL_W-1:0] res_lo
);

	localparam int SW = $clog2(VAL_W);

	logic          busy_q;
	logic          done_q;
	logic          div_q;
	logic [SW-1:0] step_q;
	logic [VAL_W-1:0] hi_q;
	logic [VAL_W-1:0] lo_q;
	logic [VAL_W-1:0] d_q;

	logic [VAL_W:0] mul_sum;
	logic [VAL_W:0] div_sh;
	logic [VAL_W:0] div_diff;
	logic           div_ge;

	assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, d_q} : '0);
	assign div_sh   = {hi_q, lo_q[VAL_W-1]};
	assign div_ge   = div_sh >= {1'b0, d_q};
	assign div_diff = div_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= SW'(VAL_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The multiplier sits in lo and shifts out as the product shifts in from hi.
	// For a divide, lo holds the dividend turning into the quotient, hi the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			hi_q  <= '0;
			lo_q  <= req.is_div ? op_a : op_b;
			d_q   <= req.is_div ? op_b : op_a;
		end else if (busy_q) begin
			if (div_q) begin
				hi_q <= div_ge ? div_diff[VAL_W-1:0] : div_sh[VAL_W-1:0];
				lo_q <= {lo_q[VAL_W-2:0], div_ge};
			end else begin
				hi_q <= mul_sum[VAL_W:1];
				lo_q <= {mul_sum[0], lo_q[VAL_W-1:1]};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign res_hi   = hi_q;
	assign res_lo   = lo_q;

endmodule
